### rtl/ple_pkg.sv
package ple_pkg;

	// default sizing of the list store
	localparam int unsigned DEPTH_DEF      = 64;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	// fixed port field widths
	localparam int unsigned OP_W    = 2;
	localparam int unsigned POS_W   = 7;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned IN_TDATA_W  = 48;
	localparam int unsigned OUT_TDATA_W = 48;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2,
		OP_LAST   = 2'd3
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SHIFT = 6'b000010,
		S_WRITE = 6'b000100,
		S_READ  = 6'b001000,
		S_CAPT  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

endpackage

### rtl/ple_ram.sv
module ple_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write one word, read one word with a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/positional_list_engine_core.sv
// Positional list engine: an ordered list of data words kept in a synchronous RAM.
// Input stream (s_axis_*): one beat per operation; tdata carries opcode, position
// and value. Output stream (m_axis_*): exactly one beat per operation with the read
// value, a status code and the entry count after the operation.
// Insert places the value before the position (append at or past the count), remove
// deletes the entry at min(position, count-1), read returns the entry at a position,
// read-last returns the tail entry.
// Insert and remove move every entry behind the position by one place, one RAM read
// and one RAM write per cycle; at most DEPTH-1 entries are moved. The shift loop runs
// through the single RAM read port. One operation is in progress at a time. The
// result sits in an output register, so the next beat is taken while an earlier
// result still waits; a stalled receiver holds the finished result inside the block
// until the output register frees up.
// Reset clears the count and the handshake state; the RAM is not cleared, since only
// entries below the count are ever read.
module positional_list_engine_core #(
	parameter int unsigned DEPTH      = ple_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [1:0] opcode, [8:2] position, [40:9] value, [47:41] zero
	input  logic [ple_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [31:0] read_value, [33:32] status, [40:34] entry_count, [47:41] zero
	output logic [ple_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned PW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

	ple_pkg::state_t  state_q;
	ple_pkg::opcode_t op_q;
	ple_pkg::status_t res_st_q;
	logic [AW-1:0]               ptr_q;
	logic [AW-1:0]               stop_q;
	logic                        issue_q;
	logic                        pend_s1;
	logic [AW-1:0]               dst_s1;
	logic [DATA_WIDTH-1:0]       wval_q;
	logic [CW-1:0]               total_q;
	logic [ple_pkg::VALUE_W-1:0] res_val_q;
	logic                        m_tvalid_q;
	logic [ple_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	ple_pkg::opcode_t in_op;
	logic [PW-1:0]    pos_w;
	logic [PW-1:0]    tot_w;
	logic [PW-1:0]    tot_m1;
	logic [PW-1:0]    p_ins;
	logic [PW-1:0]    p_rem;
	logic             accept;
	logic             out_free;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic [DATA_WIDTH-1:0] ram_rdata;

	// decode the incoming beat
	assign in_op    = ple_pkg::opcode_t'(s_axis_tdata[1:0]);
	assign pos_w    = PW'(s_axis_tdata[8:2]);
	assign tot_w    = PW'(total_q);
	assign tot_m1   = tot_w - PW'(1);
	assign p_ins    = (pos_w > tot_w) ? tot_w : pos_w;
	assign p_rem    = (pos_w > tot_m1) ? tot_m1 : pos_w;
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_tvalid_q || m_axis_tready;

	assign s_axis_tready = (state_q == ple_pkg::S_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	// steer the RAM write port: shift write-back or the final insert write
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = dst_s1;
		ram_wdata = ram_rdata;
		if (state_q == ple_pkg::S_SHIFT && pend_s1) begin
			ram_we = 1'b1;
		end else if (state_q == ple_pkg::S_WRITE) begin
			ram_we    = 1'b1;
			ram_waddr = stop_q;
			ram_wdata = wval_q;
		end
	end

	ple_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	// sequence one operation: take the beat, shift or read, then hand over the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ple_pkg::S_IDLE;
			op_q       <= ple_pkg::OP_INSERT;
			res_st_q   <= ple_pkg::ST_OK;
			ptr_q      <= '0;
			stop_q     <= '0;
			dst_s1     <= '0;
			wval_q     <= '0;
			res_val_q  <= '0;
			m_tdata_q  <= '0;
			total_q    <= '0;
			issue_q    <= 1'b0;
			pend_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// drop a taken beat unless a new result replaces it this cycle
			if (m_tvalid_q && m_axis_tready && state_q != ple_pkg::S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ple_pkg::S_IDLE: begin
					if (accept) begin
						op_q      <= in_op;
						res_val_q <= '0;
						pend_s1   <= 1'b0;
						wval_q    <= DATA_WIDTH'(s_axis_tdata[40:9]);
						case (in_op)
							ple_pkg::OP_INSERT: begin
								if (tot_w == PW'(DEPTH)) begin
									res_st_q <= ple_pkg::ST_FULL;
									state_q  <= ple_pkg::S_DONE;
								end else begin
									res_st_q <= ple_pkg::ST_OK;
									ptr_q    <= AW'(tot_m1);
									stop_q   <= AW'(p_ins);
									issue_q  <= (tot_w > p_ins);
									total_q  <= total_q + CW'(1);
									state_q  <= ple_pkg::S_SHIFT;
								end
							end
							ple_pkg::OP_REMOVE: begin
								if (total_q == '0) begin
									res_st_q <= ple_pkg::ST_EMPTY;
									state_q  <= ple_pkg::S_DONE;
								end else begin
									res_st_q <= ple_pkg::ST_OK;
									ptr_q    <= AW'(p_rem + PW'(1));
									stop_q   <= AW'(tot_m1);
									issue_q  <= (p_rem < tot_m1);
									total_q  <= total_q - CW'(1);
									state_q  <= ple_pkg::S_SHIFT;
								end
							end
							ple_pkg::OP_READ: begin
								if (total_q == '0) begin
									res_st_q <= ple_pkg::ST_EMPTY;
									state_q  <= ple_pkg::S_DONE;
								end else if (pos_w >= tot_w) begin
									res_st_q <= ple_pkg::ST_RANGE;
									state_q  <= ple_pkg::S_DONE;
								end else begin
									res_st_q <= ple_pkg::ST_OK;
									ptr_q    <= AW'(pos_w);
									state_q  <= ple_pkg::S_READ;
								end
							end
							default: begin
								if (total_q == '0) begin
									res_st_q <= ple_pkg::ST_EMPTY;
									state_q  <= ple_pkg::S_DONE;
								end else begin
									res_st_q <= ple_pkg::ST_OK;
									ptr_q    <= AW'(tot_m1);
									state_q  <= ple_pkg::S_READ;
								end
							end
						endcase
					end
				end
				ple_pkg::S_SHIFT: begin
					// read one entry per cycle, write it back one place over next cycle
					if (issue_q) begin
						pend_s1 <= 1'b1;
						dst_s1  <= (op_q == ple_pkg::OP_INSERT) ? ptr_q + AW'(1)
						                                        : ptr_q - AW'(1);
						if (ptr_q == stop_q) begin
							issue_q <= 1'b0;
						end else if (op_q == ple_pkg::OP_INSERT) begin
							ptr_q <= ptr_q - AW'(1);
						end else begin
							ptr_q <= ptr_q + AW'(1);
						end
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							state_q <= (op_q == ple_pkg::OP_INSERT) ? ple_pkg::S_WRITE
							                                        : ple_pkg::S_DONE;
						end
					end
				end
				ple_pkg::S_WRITE: begin
					state_q <= ple_pkg::S_DONE;
				end
				ple_pkg::S_READ: begin
					state_q <= ple_pkg::S_CAPT;
				end
				ple_pkg::S_CAPT: begin
					res_val_q <= ple_pkg::VALUE_W'(ram_rdata);
					state_q   <= ple_pkg::S_DONE;
				end
				ple_pkg::S_DONE: begin
					// hold the result until the output register is free
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {7'd0, ple_pkg::COUNT_W'(total_q), res_st_q, res_val_q};
						state_q    <= ple_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= ple_pkg::S_IDLE;
				end
			endcase
		end
	end

endmodule

### verif/testbench.sv
module testbench;

	localparam int LIST_DEPTH    = int'(ple_pkg::DEPTH_DEF);
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = int'(ple_pkg::DEPTH_DEF) + 16;
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_ITEMS  = 1130;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic [ple_pkg::VALUE_W-1:0] read_value;
		ple_pkg::status_t            status;
		logic [ple_pkg::COUNT_W-1:0] entry_count;
	} list_reply_t;

	logic                            clk;
	logic                            arst_n        = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	// [1:0] opcode, [8:2] position, [40:9] value, [47:41] zero
	logic [ple_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	// [31:0] read_value, [33:32] status, [40:34] entry_count, [47:41] zero
	logic [ple_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	// shadow of the list contents and the results still owed by the block
	logic [ple_pkg::VALUE_W-1:0] list_words[$];
	list_reply_t                 pending_replies[$];

	int failures    = 0;
	int beats_sent  = 0;
	int beats_taken = 0;
	int peak_count  = 0;
	int op_tally[4];
	int status_tally[4];
	bit calm         = 1'b0;
	bit hold_request = 1'b0;

	positional_list_engine_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// apply one operation to the shadow list and return the result it owes
	function automatic list_reply_t predict_list_op(ple_pkg::opcode_t op,
			logic [ple_pkg::POS_W-1:0] pos, logic [ple_pkg::VALUE_W-1:0] val);
		list_reply_t reply;
		int          slot;
		int          fill;
		reply.read_value = '0;
		reply.status     = ple_pkg::ST_OK;
		fill             = list_words.size();
		case (op)
			ple_pkg::OP_INSERT: begin
				if (fill >= LIST_DEPTH) begin
					reply.status = ple_pkg::ST_FULL;
				end else begin
					slot = (int'(pos) > fill) ? fill : int'(pos);
					list_words.insert(slot, val);
				end
			end
			ple_pkg::OP_REMOVE: begin
				if (fill == 0) begin
					reply.status = ple_pkg::ST_EMPTY;
				end else begin
					slot = (int'(pos) >= fill) ? fill - 1 : int'(pos);
					list_words.delete(slot);
				end
			end
			ple_pkg::OP_READ: begin
				if (fill == 0)
					reply.status = ple_pkg::ST_EMPTY;
				else if (int'(pos) >= fill)
					reply.status = ple_pkg::ST_RANGE;
				else
					reply.read_value = list_words[pos];
			end
			default: begin
				if (fill == 0)
					reply.status = ple_pkg::ST_EMPTY;
				else
					reply.read_value = list_words[fill - 1];
			end
		endcase
		reply.entry_count = ple_pkg::COUNT_W'(list_words.size());
		if (list_words.size() > peak_count)
			peak_count = list_words.size();
		return reply;
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int idle_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// pick an operation from percentage weights; the remainder goes to read-last
	function automatic ple_pkg::opcode_t pick_op(int w_ins, int w_rem, int w_read);
		int r;
		r = $urandom_range(0, 99);
		if (r < w_ins)
			return ple_pkg::OP_INSERT;
		if (r < w_ins + w_rem)
			return ple_pkg::OP_REMOVE;
		if (r < w_ins + w_rem + w_read)
			return ple_pkg::OP_READ;
		return ple_pkg::OP_LAST;
	endfunction

	// mostly a position inside the list or just past it, sometimes anywhere
	function automatic int pick_position();
		if ($urandom_range(0, 99) < 70)
			return $urandom_range(0, list_words.size());
		return $urandom_range(0, 127);
	endfunction

	// offer one beat, hold it until taken, then record what it owes
	task automatic send_op(input ple_pkg::opcode_t op, input int pos,
			input logic [ple_pkg::VALUE_W-1:0] val);
		int          gap;
		logic [6:0]  pos_bits;
		list_reply_t reply;
		gap      = idle_gap();
		pos_bits = pos[6:0];
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, val, pos_bits, op};
		do @(posedge clk); while (!s_axis_tready);
		reply = predict_list_op(op, pos_bits, val);
		pending_replies.push_back(reply);
		beats_sent++;
		op_tally[op]++;
	endtask

	// remove, read and read-last on an empty list
	task automatic test_empty_list();
		send_op(ple_pkg::OP_REMOVE, 0, $urandom);
		send_op(ple_pkg::OP_READ, 0, $urandom);
		send_op(ple_pkg::OP_LAST, 0, $urandom);
		send_op(ple_pkg::OP_READ, 127, $urandom);
	endtask

	// append to empty, push to the front, insert in the middle, append at the count
	task automatic test_insert_positions();
		send_op(ple_pkg::OP_INSERT, 127, 32'hFFFF_FFFF);
		send_op(ple_pkg::OP_INSERT, 0, 32'h0000_0000);
		send_op(ple_pkg::OP_INSERT, 1, 32'hA5A5_A5A5);
		send_op(ple_pkg::OP_INSERT, 3, 32'h5A5A_5A5A);
		send_op(ple_pkg::OP_INSERT, 2, $urandom);
	endtask

	// reads at both ends, at the count and far past it
	task automatic test_reads();
		send_op(ple_pkg::OP_READ, 0, $urandom);
		send_op(ple_pkg::OP_READ, list_words.size() - 1, $urandom);
		send_op(ple_pkg::OP_READ, list_words.size(), $urandom);
		send_op(ple_pkg::OP_READ, 127, $urandom);
		send_op(ple_pkg::OP_LAST, 0, $urandom);
	endtask

	// remove past the tail, in the middle and at the head until empty
	task automatic test_remove_positions();
		send_op(ple_pkg::OP_REMOVE, 127, $urandom);
		send_op(ple_pkg::OP_REMOVE, 1, $urandom);
		send_op(ple_pkg::OP_REMOVE, 0, $urandom);
		send_op(ple_pkg::OP_REMOVE, 100, $urandom);
		send_op(ple_pkg::OP_REMOVE, 0, $urandom);
		send_op(ple_pkg::OP_LAST, 0, $urandom);
	endtask

	// fill the store, knock on a full list, then drain to empty
	task automatic test_fill_to_full();
		while (list_words.size() < LIST_DEPTH)
			send_op(ple_pkg::OP_INSERT, pick_position(), $urandom);
		send_op(ple_pkg::OP_INSERT, 0, $urandom);
		send_op(ple_pkg::OP_INSERT, 127, $urandom);
		send_op(ple_pkg::OP_READ, LIST_DEPTH - 1, $urandom);
		send_op(ple_pkg::OP_READ, LIST_DEPTH, $urandom);
		send_op(ple_pkg::OP_READ, 127, $urandom);
		send_op(ple_pkg::OP_LAST, 0, $urandom);
		while (list_words.size() > 0)
			send_op(ple_pkg::OP_REMOVE, pick_position(), $urandom);
		send_op(ple_pkg::OP_REMOVE, 127, $urandom);
	endtask

	// stall the result side for a long stretch while beats keep coming
	task automatic test_backpressure();
		hold_request = 1'b1;
		calm         = 1'b1;
		repeat (16)
			send_op(pick_op(60, 15, 15), pick_position(), $urandom);
		calm = 1'b0;
	endtask

	// runs of growth, shrinkage, stack, queue, reads and noise
	task automatic test_random_mix(input int total);
		int               left;
		int               run_len;
		int               mode;
		int               pos;
		ple_pkg::opcode_t op;
		left = total;
		while (left > 0) begin
			mode    = $urandom_range(0, 5);
			run_len = $urandom_range(20, 80);
			if (run_len > left)
				run_len = left;
			calm = ($urandom_range(0, 4) == 0);
			repeat (run_len) begin
				case (mode)
					0: begin
						op  = pick_op(65, 10, 15);
						pos = pick_position();
					end
					1: begin
						op  = pick_op(10, 65, 15);
						pos = pick_position();
					end
					2: begin
						op  = pick_op(50, 40, 5);
						pos = 0;
					end
					3: begin
						op = pick_op(50, 40, 5);
						if (op == ple_pkg::OP_INSERT)
							pos = $urandom_range(0, 1) ? 127 : list_words.size();
						else
							pos = 0;
					end
					4: begin
						op  = pick_op(10, 10, 60);
						pos = pick_position();
					end
					default: begin
						op  = ple_pkg::opcode_t'($urandom_range(0, 3));
						pos = $urandom_range(0, 127);
					end
				endcase
				send_op(op, pos, $urandom);
			end
			left -= run_len;
		end
		calm = 1'b0;
	endtask

	// result side: random stalls, calm stretches, and the long hold on request
	initial begin : result_sink
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				if (!calm && $urandom_range(0, 3) == 0) begin
					m_axis_tready <= 1'b0;
					n = idle_gap();
					repeat (n + 1) @(posedge clk);
				end
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// compare each result beat against the oldest outstanding prediction
	initial begin : reply_check
		list_reply_t seen;
		list_reply_t owed;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				seen.read_value  = m_axis_tdata[31:0];
				seen.status      = ple_pkg::status_t'(m_axis_tdata[33:32]);
				seen.entry_count = m_axis_tdata[40:34];
				beats_taken++;
				status_tally[int'(seen.status)]++;
				if (pending_replies.size() == 0) begin
					failures++;
					if (failures <= MAX_REPORTS)
						$display("unexpected result: value %h status %0d count %0d",
							seen.read_value, seen.status, seen.entry_count);
				end else begin
					owed = pending_replies.pop_front();
					if (seen.read_value !== owed.read_value || seen.status !== owed.status ||
							seen.entry_count !== owed.entry_count) begin
						failures++;
						if (failures <= MAX_REPORTS) begin
							$display("result %0d: expected value %h status %0d count %0d",
								beats_taken, owed.read_value, owed.status, owed.entry_count);
							$display("  got value %h status %0d count %0d",
								seen.read_value, seen.status, seen.entry_count);
						end
					end
				end
			end
		end
	end

	// end the run when no beat moves on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no beat moved for %0d cycles, %0d results outstanding",
			STALL_LIMIT, pending_replies.size());
		$display("status: fail");
		$finish;
	end

	initial begin : run
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_insert_positions();
		test_reads();
		test_remove_positions();
		test_fill_to_full();
		test_backpressure();
		test_random_mix(RANDOM_ITEMS);
		s_axis_tvalid <= 1'b0;

		// drain outstanding results, then allow for a stray late beat
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("ran %0d operations: %0d inserts, %0d removes, %0d reads, %0d tail reads",
			beats_sent, op_tally[ple_pkg::OP_INSERT], op_tally[ple_pkg::OP_REMOVE],
			op_tally[ple_pkg::OP_READ], op_tally[ple_pkg::OP_LAST]);
		$display("list peaked at %0d entries; outcomes: %0d ok, %0d empty, %0d full, %0d range",
			peak_count, status_tally[ple_pkg::ST_OK], status_tally[ple_pkg::ST_EMPTY],
			status_tally[ple_pkg::ST_FULL], status_tally[ple_pkg::ST_RANGE]);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
